// ===== design/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// rth_pkg
// shared types and constants of the rgb to hsl converter
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int CHAN_W      = 8;
    localparam int FRAC_W      = 16;
    localparam int LIGHT_W     = CHAN_W + 1;
    localparam int HDEN_W      = CHAN_W + 3;
    localparam int SDEN_W      = CHAN_W;
    localparam int QUEUE_DEPTH = 2;

    // classified word, waiting for the dividers
    typedef struct packed {
        logic               gray;
        logic               sat_full;
        logic [HDEN_W-1:0]  hnum;
        logic [HDEN_W-1:0]  hden;
        logic [SDEN_W-1:0]  snum;
        logic [SDEN_W-1:0]  sden;
        logic [LIGHT_W-1:0] light;
    } t_item;

    // one stage of the divider pipeline
    typedef struct packed {
        logic               gray;
        logic               sat_full;
        logic [HDEN_W-1:0]  hrem;
        logic [HDEN_W-1:0]  hden;
        logic [FRAC_W-1:0]  hq;
        logic [SDEN_W-1:0]  srem;
        logic [SDEN_W-1:0]  sden;
        logic [FRAC_W-1:0]  sq;
        logic [LIGHT_W-1:0] light;
    } t_stage;

endpackage

// ===== design/rgb_to_hsl.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl
// 8-bit rgb pixel to hue, saturation and lightness
// ----------------------------------------------------------------------------
// Takes one pixel per clock: a word is accepted when start is high and busy
// is low, and its result appears on o_hue, o_saturation and o_lightness for
// exactly one cycle with o_valid high, after one classify stage, one queue
// stage, a load stage and sixteen divider stages, one quotient bit each. The
// receiver cannot stall, so busy stays low in normal streaming; the divider
// pipeline takes a new word every cycle. Hue and saturation are truncated
// 0.16 fractions, lightness is max plus min of the channels.
// ----------------------------------------------------------------------------
module rgb_to_hsl import rth_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CHAN_W-1:0]  i_red,
    input  logic [CHAN_W-1:0]  i_green,
    input  logic [CHAN_W-1:0]  i_blue,
    output logic               o_valid,
    output logic [FRAC_W-1:0]  o_hue,
    output logic [FRAC_W-1:0]  o_saturation,
    output logic [LIGHT_W-1:0] o_lightness
);

    logic  push;
    logic  full;
    logic  pop;
    t_item f_item;
    t_item q_item;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    rth_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .o_pop   (pop),
        .o_item  (q_item)
    );

    rth_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop        (pop),
        .i_item       (q_item),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_lightness  (o_lightness)
    );

endmodule

// ===== design/rth_front.sv =====
// ----------------------------------------------------------------------------
// rth_front
// accepts a pixel, finds max and min, picks the hue sector and divisors
// ----------------------------------------------------------------------------
module rth_front import rth_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    input  logic              i_full,
    output logic              o_push,
    output t_item             o_item
);

    logic              r_fv;
    t_item             r_item;
    t_item             n_item;
    logic              accept;
    logic              advance;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] d;
    logic [LIGHT_W-1:0] s;
    logic [HDEN_W:0]   d6;
    logic [HDEN_W:0]   num;
    logic [LIGHT_W:0]  inv;

    assign busy    = r_fv && i_full;
    assign o_push  = r_fv && !i_full;
    assign advance = !r_fv || !i_full;
    assign accept  = start && !busy;
    assign o_item  = r_item;

    always_comb begin
        mx  = (i_red > i_green) ? i_red : i_green;
        mx  = (mx > i_blue) ? mx : i_blue;
        mn  = (i_red < i_green) ? i_red : i_green;
        mn  = (mn < i_blue) ? mn : i_blue;
        d   = mx - mn;
        s   = LIGHT_W'(mx) + LIGHT_W'(mn);
        d6  = (HDEN_W+1)'({d, 2'b00}) + (HDEN_W+1)'({d, 1'b0});
        inv = (LIGHT_W+1)'(2 * ((1 << CHAN_W) - 1)) - (LIGHT_W+1)'(s);
        priority if (mx == i_red) begin
            if (i_green >= i_blue) begin
                num = (HDEN_W+1)'(i_green) - (HDEN_W+1)'(i_blue);
            end else begin
                num = d6 - ((HDEN_W+1)'(i_blue) - (HDEN_W+1)'(i_green));
            end
        end else if (mx == i_green) begin
            num = (HDEN_W+1)'({d, 1'b0}) + (HDEN_W+1)'(i_blue) - (HDEN_W+1)'(i_red);
        end else begin
            num = (HDEN_W+1)'({d, 2'b00}) + (HDEN_W+1)'(i_red) - (HDEN_W+1)'(i_green);
        end
        n_item.gray  = (d == '0);
        n_item.hnum  = num[HDEN_W-1:0];
        n_item.hden  = d6[HDEN_W-1:0];
        n_item.snum  = d;
        n_item.sden  = (s < LIGHT_W'((1 << CHAN_W) - 1)) ? s[SDEN_W-1:0] : inv[SDEN_W-1:0];
        n_item.sat_full = (d == n_item.sden);
        n_item.light = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (advance) begin
            r_fv <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/rth_queue.sv =====
// ----------------------------------------------------------------------------
// rth_queue
// short fifo between the front and the divider pipeline
// ----------------------------------------------------------------------------
module rth_queue import rth_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_pop,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wp;
    logic [PW-1:0]  n_rp;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_pop  = (r_cnt != '0);
    assign o_item = r_mem[r_rp];

    always_comb begin
        n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (o_pop) begin
                r_rp <= n_rp;
            end
            unique case ({i_push, o_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== design/rth_back.sv =====
// ----------------------------------------------------------------------------
// rth_back
// two restoring dividers, one quotient bit per stage, and the result word
// ----------------------------------------------------------------------------
module rth_back import rth_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop,
    input  t_item              i_item,
    output logic               o_valid,
    output logic [FRAC_W-1:0]  o_hue,
    output logic [FRAC_W-1:0]  o_saturation,
    output logic [LIGHT_W-1:0] o_lightness
);

    logic   r_v  [FRAC_W+1];
    t_stage r_st [FRAC_W+1];
    t_stage n_st [FRAC_W+1];

    // load stage
    always_comb begin
        n_st[0].gray     = i_item.gray;
        n_st[0].sat_full = i_item.sat_full;
        n_st[0].hrem     = i_item.hnum;
        n_st[0].hden     = i_item.hden;
        n_st[0].hq       = '0;
        n_st[0].srem     = i_item.snum;
        n_st[0].sden     = i_item.sden;
        n_st[0].sq       = '0;
        n_st[0].light    = i_item.light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st[0];
    end

    for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
        logic [HDEN_W:0] hsh;
        logic [SDEN_W:0] ssh;
        logic            hbit;
        logic            sbit;

        always_comb begin
            hsh  = {r_st[k-1].hrem, 1'b0};
            ssh  = {r_st[k-1].srem, 1'b0};
            hbit = (hsh >= {1'b0, r_st[k-1].hden});
            sbit = (ssh >= {1'b0, r_st[k-1].sden});
            n_st[k]      = r_st[k-1];
            n_st[k].hrem = hbit ? HDEN_W'(hsh - {1'b0, r_st[k-1].hden}) : hsh[HDEN_W-1:0];
            n_st[k].srem = sbit ? SDEN_W'(ssh - {1'b0, r_st[k-1].sden}) : ssh[SDEN_W-1:0];
            n_st[k].hq   = {r_st[k-1].hq[FRAC_W-2:0], hbit};
            n_st[k].sq   = {r_st[k-1].sq[FRAC_W-2:0], sbit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[k] <= n_st[k];
        end
    end

    // gray pixels give zero, a full ratio clamps
    always_comb begin
        o_valid     = r_v[FRAC_W];
        o_lightness = r_st[FRAC_W].light;
        priority if (r_st[FRAC_W].gray) begin
            o_hue        = '0;
            o_saturation = '0;
        end else if (r_st[FRAC_W].sat_full) begin
            o_hue        = r_st[FRAC_W].hq;
            o_saturation = '1;
        end else begin
            o_hue        = r_st[FRAC_W].hq;
            o_saturation = r_st[FRAC_W].sq;
        end
    end

endmodule
